### rtl/mtfp_pkg.sv
package mtfp_pkg;

   localparam int unsigned FrameBytes = 14;

   localparam logic [7:0] BYTE_END        = 8'hFF;
   localparam logic [7:0] BYTE_ERR_FRAME  = 8'h10;
   localparam logic [7:0] BYTE_READ_FRAME = 8'h11;
   localparam logic [7:0] DEV_WATER       = 8'h01;
   localparam logic [7:0] STAT_CODE_OK    = 8'h00;
   localparam logic [7:0] STAT_CODE_TEMP  = 8'h10;

   localparam logic [3:0] LEN_ERROR   = 4'd5;
   localparam logic [3:0] LEN_READING = 4'd14;

   localparam logic [1:0] KIND_ERROR   = 2'd0;
   localparam logic [1:0] KIND_READING = 2'd1;
   localparam logic [1:0] KIND_UNKNOWN = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_TEMP  = 2'd1;
   localparam logic [1:0] STATUS_OTHER = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        device_kind;
      logic [31:0] serial;
      logic [1:0]  status;
      logic [6:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [31:0] counter;
      logic        truncated;
      logic        last;
   } rec_type;

   // results caused by one byte: an optional record, and an optional end record after it
   typedef struct packed {
      logic    first_valid;
      logic    second_end;
      rec_type first;
   } res_type;

   function automatic rec_type make_end(input logic trunc);
      rec_type r;
      r           = '0;
      r.kind      = KIND_END;
      r.truncated = trunc;
      r.last      = 1'b1;
      return r;
   endfunction

endpackage

### rtl/meter_telegram_frame_parser_unit.sv
// Meter telegram frame parser.
// req_ carries one telegram byte per transfer (tdata[7:0]); req_tlast marks the
// final byte of the telegram. rsp_ carries one record per transfer: rsp_tuser is
// the record kind, rsp_tdata the decoded fields, rsp_tlast the end record.
// Type 0x10 opens a 5-byte error frame, 0x11 a 14-byte reading frame; a record
// appears when the frame's final byte is taken. Other type bytes give an empty
// record, 0xFF or a flagged last byte give an end record.
// A byte is registered in the input register, then decoded combinationally into
// the result register once that register is free; its first record transfers
// out from the result register.
// Throughput: one byte per cycle while the result register is free. A byte that
// yields two records (a record plus the end record) holds the input while the
// end record is queued behind the result register.
// Reset clears the frame position, frame type and end-of-telegram flags; frame
// byte storage is not cleared. When rsp_tready is low the result register holds,
// the input register still takes one byte, then req_tready drops.
module meter_telegram_frame_parser_unit
   import mtfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] device_kind, [32:1] serial, [34:33] status, [41:35] year, [45:42] month,
   // [50:46] day, [55:51] hour, [61:56] minute, [93:62] counter, [94] truncated,
   // [95] zero
   output logic [95:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,  // [1:0] kind
   output logic        rsp_tlast   // last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       can_load;
   logic       consume;
   logic       req_xfer;
   res_type    res;
   rec_type    rec;

   assign consume    = in_valid_ff && can_load;
   assign req_tready = !in_valid_ff || consume;
   assign req_xfer   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (consume) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   mtfp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .fire      (consume),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .res       (res)
   );

   mtfp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (consume),
      .res       (res),
      .can_load  (can_load),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_rec   (rec)
   );

   assign rsp_tuser = rec.kind;
   assign rsp_tlast = rec.last;
   assign rsp_tdata = {1'b0, rec.truncated, rec.counter, rec.minute, rec.hour, rec.day,
                       rec.month, rec.year, rec.status, rec.serial, rec.device_kind};

endmodule

### rtl/mtfp_decode.sv
module mtfp_decode
   import mtfp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output res_type    res
);

   logic [3:0] bytes_left_ff, bytes_left_in;
   logic       is_reading_ff, is_reading_in;
   logic       done_ff, done_in;
   logic [7:0] frame_ff [FrameBytes];
   logic [7:0] frame_view [FrameBytes];
   logic [3:0] cur_idx;
   logic       fb_we;
   rec_type    frame_rec;
   rec_type    unknown_rec;
   logic [7:0] status_code;

   assign cur_idx = (is_reading_ff ? LEN_READING : LEN_ERROR) - bytes_left_ff;
   assign fb_we   = fire && !done_ff && (bytes_left_ff != 4'd0);

   // frame contents including the byte being taken now
   always_comb begin
      for (int i = 0; i < FrameBytes; i++) begin
         frame_view[i] = (fb_we && cur_idx == 4'(i)) ? data_byte : frame_ff[i];
      end
   end

   assign status_code = frame_view[5];

   always_comb begin
      frame_rec             = '0;
      frame_rec.kind        = is_reading_ff ? KIND_READING : KIND_ERROR;
      frame_rec.device_kind = (frame_view[0] == DEV_WATER);
      frame_rec.serial      = {frame_view[4], frame_view[3], frame_view[2], frame_view[1]};
      if (is_reading_ff) begin
         if (status_code == STAT_CODE_OK) begin
            frame_rec.status = STATUS_OK;
         end else if (status_code == STAT_CODE_TEMP) begin
            frame_rec.status = STATUS_TEMP;
         end else begin
            frame_rec.status = STATUS_OTHER;
         end
         // type F: year bits split over the two date bytes
         frame_rec.year    = {frame_view[9][7:4], frame_view[8][7:5]};
         frame_rec.month   = frame_view[9][3:0];
         frame_rec.day     = frame_view[8][4:0];
         frame_rec.hour    = frame_view[7][4:0];
         frame_rec.minute  = frame_view[6][5:0];
         frame_rec.counter = {frame_view[13], frame_view[12], frame_view[11], frame_view[10]};
      end
   end

   always_comb begin
      unknown_rec      = '0;
      unknown_rec.kind = KIND_UNKNOWN;
   end

   always_comb begin
      res           = '0;
      bytes_left_in = bytes_left_ff;
      is_reading_in = is_reading_ff;
      done_in       = done_ff;
      if (fire) begin
         if (done_ff) begin
            if (last_byte) begin
               done_in = 1'b0;
            end
         end else if (bytes_left_ff == 4'd0 && data_byte == BYTE_END) begin
            res.first_valid = 1'b1;
            res.first       = make_end(1'b0);
            done_in         = !last_byte;
         end else begin
            if (bytes_left_ff == 4'd0) begin
               case (data_byte)
                  BYTE_ERR_FRAME: begin
                     bytes_left_in = LEN_ERROR;
                     is_reading_in = 1'b0;
                  end
                  BYTE_READ_FRAME: begin
                     bytes_left_in = LEN_READING;
                     is_reading_in = 1'b1;
                  end
                  default: begin
                     res.first_valid = 1'b1;
                     res.first       = unknown_rec;
                  end
               endcase
            end else begin
               bytes_left_in = bytes_left_ff - 4'd1;
               if (bytes_left_ff == 4'd1) begin
                  res.first_valid = 1'b1;
                  res.first       = frame_rec;
               end
            end
            if (last_byte) begin
               if (res.first_valid) begin
                  res.second_end = 1'b1;
               end else begin
                  res.first_valid = 1'b1;
                  res.first       = make_end(bytes_left_in != 4'd0);
               end
               bytes_left_in = 4'd0;
               is_reading_in = 1'b0;
               done_in       = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 4'd0;
         is_reading_ff <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         bytes_left_ff <= bytes_left_in;
         is_reading_ff <= is_reading_in;
         done_ff       <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < FrameBytes; i++) begin
         if (fb_we && cur_idx == 4'(i)) begin
            frame_ff[i] <= data_byte;
         end
      end
   end

endmodule

### rtl/mtfp_out_stage.sv
module mtfp_out_stage
   import mtfp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load,
   input  res_type res,
   output logic    can_load,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rec_type rsp_rec
);

   logic    valid_ff, valid_in;
   logic    end_pend_ff, end_pend_in;
   rec_type rec_ff, rec_in;
   logic    slot_free;

   assign slot_free = !valid_ff || rsp_ready;
   assign can_load  = !end_pend_ff && slot_free;
   assign rsp_valid = valid_ff;
   assign rsp_rec   = rec_ff;

   always_comb begin
      valid_in    = valid_ff;
      end_pend_in = end_pend_ff;
      rec_in      = rec_ff;
      if (end_pend_ff && slot_free) begin
         valid_in    = 1'b1;
         end_pend_in = 1'b0;
         rec_in      = make_end(1'b0);
      end else if (load && res.first_valid) begin
         valid_in    = 1'b1;
         end_pend_in = res.second_end;
         rec_in      = res.first;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         end_pend_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         end_pend_ff <= end_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   // a queued end record always sits behind a record on display
   a_pend_has_head: assert property (@(posedge clock) disable iff (reset)
      end_pend_ff |-> valid_ff && rec_ff.kind != KIND_END)
      else $error("end record queued without a leading record");

   a_pend_follows: assert property (@(posedge clock) disable iff (reset)
      end_pend_ff && rsp_ready |=> valid_ff && rec_ff.kind == KIND_END && rec_ff.last
                                   && !rec_ff.truncated)
      else $error("queued end record not presented next");

   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rec_ff.last == (rec_ff.kind == KIND_END)))
      else $error("last flag disagrees with record kind");

   a_no_load_while_pend: assert property (@(posedge clock) disable iff (reset)
      end_pend_ff |-> !can_load)
      else $error("item taken while end record pending");

endmodule

### tb/sv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mtfp_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;

   // one telegram byte to offer; typed rows carry their own expected records
   typedef struct {
      logic [7:0] b;
      logic       l;
      bit         typed;
      int         n;
      rec_type    r1;
      rec_type    r2;
   } byte_stim_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int errors;
   int snd_idle_pct;
   int rcv_stall_pct;
   bit hold_req = 1'b0;

   rec_type       record_q [$];    // records still owed by the parser
   byte_stim_type offered_q [$];   // bytes offered, in transfer order
   byte_stim_type telegram_q [$];  // bytes built but not yet offered

   // parser state as predicted
   logic [3:0] pos_left;
   logic       in_reading;
   logic       after_end;
   logic [7:0] frame_buf [14];

   meter_telegram_frame_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic rec_type mk_rec(logic [1:0] kind, logic dev, logic [31:0] serial,
                                      logic [1:0] status, logic [6:0] year,
                                      logic [3:0] month, logic [4:0] day, logic [4:0] hour,
                                      logic [5:0] minute, logic [31:0] counter,
                                      logic trunc, logic last);
      rec_type r;
      r.kind        = kind;
      r.device_kind = dev;
      r.serial      = serial;
      r.status      = status;
      r.year        = year;
      r.month       = month;
      r.day         = day;
      r.hour        = hour;
      r.minute      = minute;
      r.counter     = counter;
      r.truncated   = trunc;
      r.last        = last;
      return r;
   endfunction

   // records caused by one accepted byte, in order; returns how many
   function automatic int decode_byte(input logic [7:0] b, input logic l,
                                      output rec_type r [2]);
      int         n;
      logic [3:0] idx;
      n    = 0;
      r[0] = '0;
      r[1] = '0;
      if (after_end) begin
         if (l) after_end = 1'b0;
         return 0;
      end
      if (pos_left == 4'd0) begin
         if (b == BYTE_END) begin
            r[0] = make_end(1'b0);
            after_end = !l;
            return 1;
         end
         if (b == BYTE_ERR_FRAME) begin
            pos_left   = LEN_ERROR;
            in_reading = 1'b0;
         end else if (b == BYTE_READ_FRAME) begin
            pos_left   = LEN_READING;
            in_reading = 1'b1;
         end else begin
            r[0].kind = KIND_UNKNOWN;
            n = 1;
         end
      end else begin
         idx = (in_reading ? LEN_READING : LEN_ERROR) - pos_left;
         frame_buf[idx] = b;
         pos_left = pos_left - 4'd1;
         if (pos_left == 4'd0) begin
            r[0].kind        = in_reading ? KIND_READING : KIND_ERROR;
            r[0].device_kind = (frame_buf[0] == DEV_WATER);
            r[0].serial      = {frame_buf[4], frame_buf[3], frame_buf[2], frame_buf[1]};
            if (in_reading) begin
               r[0].status  = (frame_buf[5] == STAT_CODE_OK)   ? STATUS_OK :
                              (frame_buf[5] == STAT_CODE_TEMP) ? STATUS_TEMP : STATUS_OTHER;
               // type F: year high nibble in byte 3, low three bits on top of byte 2
               r[0].year    = {frame_buf[9][7:4], frame_buf[8][7:5]};
               r[0].month   = frame_buf[9][3:0];
               r[0].day     = frame_buf[8][4:0];
               r[0].hour    = frame_buf[7][4:0];
               r[0].minute  = frame_buf[6][5:0];
               r[0].counter = {frame_buf[13], frame_buf[12], frame_buf[11], frame_buf[10]};
            end
            n = 1;
         end
      end
      if (l) begin
         r[n] = make_end(pos_left != 4'd0);
         n++;
         pos_left   = 4'd0;
         in_reading = 1'b0;
         after_end  = 1'b0;
      end
      return n;
   endfunction

   task automatic chk(input string name, input logic [31:0] e, input logic [31:0] a);
      if (a !== e) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, e, a);
         errors++;
      end
   endtask

   task automatic check_rec(input rec_type e, input rec_type a);
      chk("kind", 32'(e.kind), 32'(a.kind));
      chk("device_kind", 32'(e.device_kind), 32'(a.device_kind));
      chk("serial", e.serial, a.serial);
      chk("status", 32'(e.status), 32'(a.status));
      chk("year", 32'(e.year), 32'(a.year));
      chk("month", 32'(e.month), 32'(a.month));
      chk("day", 32'(e.day), 32'(a.day));
      chk("hour", 32'(e.hour), 32'(a.hour));
      chk("minute", 32'(e.minute), 32'(a.minute));
      chk("counter", e.counter, a.counter);
      chk("truncated", 32'(e.truncated), 32'(a.truncated));
      chk("last", 32'(e.last), 32'(a.last));
   endtask

   // results are checked before the byte of the same edge is predicted
   always @(posedge clock) begin : monitor_blk
      rec_type       got;
      rec_type       recs [2];
      byte_stim_type s;
      int            n;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind        = rsp_tuser;
            got.device_kind = rsp_tdata[0];
            got.serial      = rsp_tdata[32:1];
            got.status      = rsp_tdata[34:33];
            got.year        = rsp_tdata[41:35];
            got.month       = rsp_tdata[45:42];
            got.day         = rsp_tdata[50:46];
            got.hour        = rsp_tdata[55:51];
            got.minute      = rsp_tdata[61:56];
            got.counter     = rsp_tdata[93:62];
            got.truncated   = rsp_tdata[94];
            got.last        = rsp_tlast;
            if (record_q.size() == 0) begin
               $error("record of kind %0d with nothing expected", rsp_tuser);
               errors++;
            end else begin
               check_rec(record_q.pop_front(), got);
            end
         end
         if (req_tvalid && req_tready) begin
            n = decode_byte(req_tdata, req_tlast, recs);
            if (offered_q.size() != 0) begin
               s = offered_q.pop_front();
               if (s.typed) begin
                  n       = s.n;
                  recs[0] = s.r1;
                  recs[1] = s.r2;
               end
            end
            for (int i = 0; i < n; i++) record_q.insert(record_q.size(), recs[i]);
         end
      end
   end

   // receiver: random stalls, or a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_stall_pct);
         end
      end
   end

   function automatic void add_row(logic [7:0] b, logic l, bit typed = 1'b0, int n = 0,
                                   rec_type r1 = '0, rec_type r2 = '0);
      byte_stim_type s;
      s.b     = b;
      s.l     = l;
      s.typed = typed;
      s.n     = n;
      s.r1    = r1;
      s.r2    = r2;
      telegram_q.insert(telegram_q.size(), s);
   endfunction

   // type byte and the first nbytes of its frame body
   function automatic void add_frame(logic [7:0] ty, int nbytes);
      logic [7:0] v;
      add_row(ty, 1'b0);
      for (int i = 0; i < nbytes; i++) begin
         v = 8'($urandom_range(255));
         if (i == 0 && $urandom_range(1) == 0) v = DEV_WATER;
         if (i == 5 && ty == BYTE_READ_FRAME) begin
            case ($urandom_range(2))
               0: v = STAT_CODE_OK;
               1: v = STAT_CODE_TEMP;
               default: ;
            endcase
         end
         add_row(v, 1'b0);
      end
   endfunction

   function automatic void gen_telegram();
      int         nfr;
      int         k;
      logic [7:0] ty;
      logic [7:0] v;
      nfr = $urandom_range(1, 4);
      for (int f = 0; f < nfr; f++) begin
         k = $urandom_range(99);
         if (k < 75) begin
            ty = (k < 40) ? BYTE_READ_FRAME : BYTE_ERR_FRAME;
            add_frame(ty, int'((ty == BYTE_READ_FRAME) ? LEN_READING : LEN_ERROR));
         end else begin
            do v = 8'($urandom_range(255));
            while (v == BYTE_END || v == BYTE_ERR_FRAME || v == BYTE_READ_FRAME);
            add_row(v, 1'b0);
         end
      end
      k = $urandom_range(99);
      if (k < 45) begin
         telegram_q[telegram_q.size() - 1].l = 1'b1;
      end else if (k < 65) begin
         add_row(BYTE_END, 1'b1);
      end else if (k < 80) begin
         // end byte not flagged: the rest up to the flagged byte is skipped
         add_row(BYTE_END, 1'b0);
         repeat ($urandom_range(3)) add_row(8'($urandom_range(255)), 1'b0);
         add_row(8'($urandom_range(255)), 1'b1);
      end else begin
         ty = $urandom_range(1) ? BYTE_READ_FRAME : BYTE_ERR_FRAME;
         add_frame(ty, int'($urandom_range(
                      int'((ty == BYTE_READ_FRAME) ? LEN_READING : LEN_ERROR) - 1)));
         telegram_q[telegram_q.size() - 1].l = 1'b1;
      end
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_byte(input byte_stim_type s);
      offered_q.insert(offered_q.size(), s);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s.b;
      req_tlast  <= s.l;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic send_all();
      while (telegram_q.size() != 0) send_byte(telegram_q.pop_front());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (record_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic run_phase(input int n_items, input int snd, input int rcv,
                            input bit hold, input bit pause_mid);
      int sent;
      bit paused;
      sent   = 0;
      paused = 1'b0;
      @(posedge clock);
      snd_idle_pct  = snd;
      rcv_stall_pct = rcv;
      hold_req      = hold;
      @(negedge clock);
      while (sent < n_items) begin
         gen_telegram();
         sent += telegram_q.size();
         send_all();
         if (pause_mid && !paused && sent >= n_items / 2) begin
            paused = 1'b1;
            drain();
         end
      end
      drain();
   endtask

   initial begin
      rec_type nil;
      nil           = '0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tlast     = 1'b0;
      errors        = 0;
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      pos_left      = 4'd0;
      in_reading    = 1'b0;
      after_end     = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      add_row(BYTE_END, 1'b0, 1'b1, 1, make_end(1'b0));
      add_row(8'h42, 1'b0, 1'b1, 0);   // skipped after the end byte
      add_row(BYTE_END, 1'b1, 1'b1, 0);  // flagged byte only clears the skip
      add_row(8'h00, 1'b0, 1'b1, 1,
              mk_rec(KIND_UNKNOWN, 1'b0, 32'h0, STATUS_OK, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0,
                     32'h0, 1'b0, 1'b0));
      // error frame, all-ones serial: 0xFF inside a frame is plain data
      add_row(BYTE_ERR_FRAME, 1'b0);
      add_row(DEV_WATER, 1'b0);
      repeat (3) add_row(8'hFF, 1'b0);
      add_row(8'hFF, 1'b0, 1'b1, 1,
              mk_rec(KIND_ERROR, 1'b1, 32'hFFFF_FFFF, STATUS_OK, 7'd0, 4'd0, 5'd0, 5'd0,
                     6'd0, 32'h0, 1'b0, 1'b0));
      // reading frame closed by the flagged byte: record, then end record
      add_row(BYTE_READ_FRAME, 1'b0);
      repeat (5) add_row(8'h00, 1'b0);
      add_row(STAT_CODE_TEMP, 1'b0);
      repeat (7) add_row(8'hFF, 1'b0);
      add_row(8'hFF, 1'b1, 1'b1, 2,
              mk_rec(KIND_READING, 1'b0, 32'h0, STATUS_TEMP, 7'd127, 4'hF, 5'h1F, 5'h1F,
                     6'h3F, 32'hFFFF_FFFF, 1'b0, 1'b0),
              make_end(1'b0));
      // telegram ends inside a frame
      add_row(BYTE_READ_FRAME, 1'b0);
      add_row(8'h05, 1'b1, 1'b1, 1, make_end(1'b1));
      add_row(8'h7E, 1'b1, 1'b1, 2,
              mk_rec(KIND_UNKNOWN, 1'b0, 32'h0, STATUS_OK, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0,
                     32'h0, 1'b0, 1'b0),
              make_end(1'b0));
      add_row(BYTE_END, 1'b1, 1'b1, 1, make_end(1'b0));
      add_row(8'h10, 1'b0, 1'b0, 0, nil, nil);
      add_row(8'h3C, 1'b1);
      send_all();
      drain();

      run_phase(400, 0, 0, 1'b1, 1'b0);
      run_phase(400, 85, 0, 1'b0, 1'b1);
      run_phase(450, 0, 85, 1'b0, 1'b0);
      run_phase(400, 15, 15, 1'b0, 1'b0);

      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### files.f
rtl/mtfp_pkg.sv
rtl/mtfp_decode.sv
rtl/mtfp_out_stage.sv
rtl/meter_telegram_frame_parser_unit.sv
tb/sv/tb_top.sv
